### hdl/dic_pkg.sv
// Package for the dual instruction set classifier.
// Holds the class codes, the decode masks and the two classify functions.
// No dependencies.
`default_nettype none

package dic_pkg;

    // Width of a class code.
    localparam int ClassW = 6;

    typedef logic [ClassW-1:0] class_t;

    // 32-bit classes.
    localparam class_t CLS_SWAP        = 6'd0;
    localparam class_t CLS_MUL         = 6'd1;
    localparam class_t CLS_HALF_REG    = 6'd2;
    localparam class_t CLS_HALF_IMM    = 6'd3;
    localparam class_t CLS_BX          = 6'd4;
    localparam class_t CLS_PSR_READ    = 6'd5;
    localparam class_t CLS_PSR_WRITE   = 6'd6;
    localparam class_t CLS_ALU         = 6'd7;
    localparam class_t CLS_LDST_IMM    = 6'd8;
    localparam class_t CLS_LDST_REG    = 6'd9;
    localparam class_t CLS_BLOCK       = 6'd10;
    localparam class_t CLS_BRANCH      = 6'd11;
    localparam class_t CLS_CP_XFER     = 6'd12;
    localparam class_t CLS_CP_REG      = 6'd13;
    localparam class_t CLS_CP_DATA     = 6'd14;
    localparam class_t CLS_SWI         = 6'd15;

    // 16-bit classes.
    localparam class_t CLS_T_ADDSUB    = 6'd16;
    localparam class_t CLS_T_SHIFT     = 6'd17;
    localparam class_t CLS_T_IMM       = 6'd18;
    localparam class_t CLS_T_ALU       = 6'd19;
    localparam class_t CLS_T_HIREG     = 6'd20;
    localparam class_t CLS_T_PCLOAD    = 6'd21;
    localparam class_t CLS_T_LDST_REG  = 6'd22;
    localparam class_t CLS_T_LDST_SX   = 6'd23;
    localparam class_t CLS_T_LDST_IMM  = 6'd24;
    localparam class_t CLS_T_LDST_HALF = 6'd25;
    localparam class_t CLS_T_SP_LDST   = 6'd26;
    localparam class_t CLS_T_LDADDR    = 6'd27;
    localparam class_t CLS_T_SP_ADD    = 6'd28;
    localparam class_t CLS_T_PUSHPOP   = 6'd29;
    localparam class_t CLS_T_MULTI     = 6'd30;
    localparam class_t CLS_T_SWI       = 6'd31;
    localparam class_t CLS_T_BCOND     = 6'd32;
    localparam class_t CLS_T_B         = 6'd33;
    localparam class_t CLS_T_BL        = 6'd34;
    localparam class_t CLS_NONE        = 6'd35;

    // Masks and match patterns of the 32-bit tests.
    localparam logic [31:0] BX_MASK    = 32'h01FF_FF00;
    localparam logic [31:0] BX_MATCH   = 32'h012F_FF00;
    localparam logic [31:0] MRS_MASK   = 32'h019F_0FFF;
    localparam logic [31:0] MRS_MATCH  = 32'h010F_0000;
    localparam logic [31:0] MSR_MASK   = 32'h0190_F000;
    localparam logic [31:0] MSR_MATCH  = 32'h0100_F000;
    localparam logic [31:0] SWP_MASK   = 32'h01B0_0000;
    localparam logic [31:0] SWP_MATCH  = 32'h0100_0000;
    localparam logic [31:0] HALF_MASK  = 32'h0040_0F00;
    localparam logic [31:0] CP_MASK    = 32'h0F00_0010;
    localparam logic [31:0] CP_REG_VAL = 32'h0E00_0010;
    localparam logic [31:0] CP_DAT_VAL = 32'h0E00_0000;

    // Classify a word of the 32-bit set.
    function automatic class_t classify_wide(input logic [31:0] w);
        class_t r;
        r = CLS_ALU;
        case (w[27:25])
            3'd0:
            begin
                if (w[7] && w[4])
                begin
                    if (w[7:4] == 4'h9)
                        r = ((w & SWP_MASK) == SWP_MATCH) ? CLS_SWAP : CLS_MUL;
                    else
                        r = ((w & HALF_MASK) == 32'h0) ? CLS_HALF_REG : CLS_HALF_IMM;
                end
                else if ((w & BX_MASK) == BX_MATCH)
                    r = CLS_BX;
                else if ((w & MRS_MASK) == MRS_MATCH)
                    r = CLS_PSR_READ;
                else if ((w & MSR_MASK) == MSR_MATCH)
                    r = CLS_PSR_WRITE;
                else
                    r = CLS_ALU;
            end
            3'd1:
            begin
                if ((w & MRS_MASK) == MRS_MATCH)
                    r = CLS_PSR_READ;
                else if ((w & MSR_MASK) == MSR_MATCH)
                    r = CLS_PSR_WRITE;
                else
                    r = CLS_ALU;
            end
            3'd2: r = CLS_LDST_IMM;
            3'd3: r = CLS_LDST_REG;
            3'd4: r = CLS_BLOCK;
            3'd5: r = CLS_BRANCH;
            3'd6: r = CLS_CP_XFER;
            default:
            begin
                if ((w & CP_MASK) == CP_REG_VAL)
                    r = CLS_CP_REG;
                else if ((w & CP_MASK) == CP_DAT_VAL)
                    r = CLS_CP_DATA;
                else
                    r = CLS_SWI;
            end
        endcase
        return r;
    endfunction

    // Classify a halfword of the 16-bit set.
    function automatic class_t classify_compact(input logic [15:0] h);
        class_t r;
        r = CLS_NONE;
        case (h[15:13])
            3'd0: r = (h[12:11] == 2'b11) ? CLS_T_ADDSUB : CLS_T_SHIFT;
            3'd1: r = CLS_T_IMM;
            3'd2:
            begin
                if (h[12:10] == 3'b000)
                    r = CLS_T_ALU;
                else if (h[12:10] == 3'b001)
                    r = CLS_T_HIREG;
                else if (h[12:11] == 2'b01)
                    r = CLS_T_PCLOAD;
                else if (h[12] && !h[9])
                    r = CLS_T_LDST_REG;
                else if (h[12] && h[9])
                    r = CLS_T_LDST_SX;
                else
                    r = CLS_NONE;
            end
            3'd3: r = CLS_T_LDST_IMM;
            3'd4: r = h[12] ? CLS_T_SP_LDST : CLS_T_LDST_HALF;
            3'd5:
            begin
                // Push/pop ignores bit 11 (load or store) and bit 8 (link register).
                if (!h[12])
                    r = CLS_T_LDADDR;
                else if (h[11:8] == 4'h0)
                    r = CLS_T_SP_ADD;
                else if (h[10:9] == 2'b10)
                    r = CLS_T_PUSHPOP;
                else
                    r = CLS_NONE;
            end
            3'd6:
            begin
                if (!h[12])
                    r = CLS_T_MULTI;
                else if (h[11:8] == 4'hF)
                    r = CLS_T_SWI;
                else
                    r = CLS_T_BCOND;
            end
            default:
            begin
                if (h[12:11] == 2'b00)
                    r = CLS_T_B;
                else if (h[12])
                    r = CLS_T_BL;
                else
                    r = CLS_NONE;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/dual_isa_instruction_classifier.sv
// Top level of the dual instruction set classifier.
// Depends on dic_pkg for the class codes and the classify functions.
//
// The block takes one instruction word per item and returns one item with
// the instruction class and the condition field. It is a two-stage pipeline:
// an input register, then the mask decode, then a result register. An accepted
// item moves from the input register into the result register, which raises
// out_valid; a new item is accepted in every cycle while the output side keeps
// taking results. When the output is stalled, one further item is still taken
// into the input register before in_stall rises. The condition field is passed
// through unevaluated and is zero for 16-bit words; 16-bit words that match no
// encoding give class 35.
`default_nettype none

module dual_isa_instruction_classifier
    import dic_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] instruction_word,
    input  wire logic        compact_state,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       instr_class,
    output logic [3:0]       condition_code
);

    logic        s1_valid_reg;
    logic [31:0] word_reg;
    logic        compact_reg;
    logic        out_valid_reg;
    class_t      class_reg;
    logic [3:0]  cond_reg;

    logic        out_hold;
    logic        s1_hold;
    logic        s1_load;
    class_t      class_next;
    logic [3:0]  cond_next;

    // Stall chain: a stage holds when it is full and the next one cannot take.
    assign out_hold = out_valid_reg && out_stall;
    assign s1_hold  = s1_valid_reg && out_hold;
    assign in_stall = s1_hold;
    assign s1_load  = in_valid && !s1_hold;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!s1_hold)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            word_reg    <= instruction_word;
            compact_reg <= compact_state;
        end
    end

    // Decode between the two registers.
    always_comb
    begin
        if (compact_reg)
        begin
            class_next = classify_compact(word_reg[15:0]);
            cond_next  = 4'h0;
        end
        else
        begin
            class_next = classify_wide(word_reg);
            cond_next  = word_reg[31:28];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_hold)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!out_hold && s1_valid_reg)
        begin
            class_reg <= class_next;
            cond_reg  <= cond_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign instr_class    = class_reg;
    assign condition_code = cond_reg;

`ifndef SYNTHESIS
    // Input side stalls only while both stages are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("in_stall raised with a free stage");

    // A class code never exceeds the none code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (instr_class <= CLS_NONE))
        else $error("class code out of range");

    // 16-bit classes carry a zero condition field.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (instr_class >= CLS_T_ADDSUB)) |-> (condition_code == 4'h0))
        else $error("nonzero condition on a 16-bit class");

    // An item in the input register reaches the output unless it is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_hold) |=> out_valid_reg)
        else $error("item lost between stages");
`endif

endmodule

`default_nettype wire
